// File: rtl/srgb_pkg.sv
// ----------------------------------------------------------------------------
// srgb_pkg
// Types, constants and small helpers for the shared rgb led blink controller.
// ----------------------------------------------------------------------------
package srgb_pkg;

    localparam int COLOR_W   = 24;
    localparam int MODE_W    = 2;
    localparam int MS_W      = 16;
    localparam int LEVEL_W   = 12;
    localparam int BYTE_W    = 8;
    localparam int STEPS     = 16;
    localparam int K_W       = 4;
    localparam int NUM_W     = 20;
    localparam int DEN_W     = 17;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0]     CMD_BACKLIGHT = 2'd3;
    localparam logic [LEVEL_W-1:0]   FULL_SCALE    = 12'd255;
    localparam logic [DEN_W-1:0]     BYTE_DIVISOR  = 17'd255;
    localparam logic [BYTE_W-1:0]    LUMA_R        = 8'd77;
    localparam logic [BYTE_W-1:0]    LUMA_G        = 8'd150;
    localparam logic [BYTE_W-1:0]    LUMA_B        = 8'd29;

    localparam logic [CFG_IDX_W-1:0] REG_RED_MAX       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLIGHT_MAX = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV1,
        S_DIV2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MS_W-1:0]    off_ms;
        logic [MS_W-1:0]    on_ms;
        logic [MODE_W-1:0]  mode;
        logic [COLOR_W-1:0] color;
    } t_slot;

    // 0 in the max register stands for 255
    function automatic logic [LEVEL_W-1:0] eff_max(input logic [LEVEL_W-1:0] m);
        eff_max = (m == '0) ? FULL_SCALE : m;
    endfunction

    // row k lights steps 8-floor((k+1)/2) through 8+floor(k/2)
    function automatic logic [STEPS-1:0] row_mask(input logic [K_W-1:0] k);
        logic [K_W:0] lo;
        logic [K_W:0] hi;
        lo = 5'd8 - ((5'(k) + 5'd1) >> 1);
        hi = 5'd8 + (5'(k) >> 1);
        for (int j = 0; j < STEPS; j++) begin
            row_mask[j] = (5'(j) >= lo) && (5'(j) <= hi);
        end
    endfunction

endpackage

// File: rtl/shared_rgb_led_blink_controller_unit.sv
// ----------------------------------------------------------------------------
// shared_rgb_led_blink_controller_unit
// backlight and solid updates run the parallel divisions, a flashing slot
// with nonzero off time then a second 20-step serial division for its step time;
// a new item waits until the last result is in the output register (held by stalls);
// synchronous active-low reset: slots dark, all max registers 255
// ----------------------------------------------------------------------------
module shared_rgb_led_blink_controller_unit
    import srgb_pkg::*;
#(
    parameter int SLOT_COUNT = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // fields from bit 0: color[23:0], flash_mode[25:24], flash_on_ms[41:26],
    // flash_off_ms[57:42], zero fill
    input  logic [63:0]          i_s_axis_tdata,
    // fields from bit 0: cmd[1:0]
    input  logic [CMD_W-1:0]     i_s_axis_tuser,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // fields from bit 0: sync_on[0], blink_active[1], pattern_on[2],
    // pattern_mask[18:3], red_level[30:19], green_level[42:31],
    // blue_level[54:43], step_ms[70:55], backlight_level[82:71], zero fill
    output logic [87:0]          o_m_axis_tdata,
    // fields from bit 0: kind[0]
    output logic                 o_m_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_data
);

    t_state r_state, n_state;

    t_slot               r_slot [SLOT_COUNT];
    logic [LEVEL_W-1:0]  r_red_max, r_green_max, r_blue_max, r_bl_max;

    logic                r_kind;
    logic [BYTE_W-1:0]   r_luma;
    logic                r_sync;
    logic                r_blink;
    logic [MS_W-1:0]     r_on;
    logic [K_W-1:0]      r_k;
    logic [MS_W-1:0]     r_dur;

    logic                r_out_valid;
    logic                r_out_kind;
    logic [87:0]         r_out_data;

    logic                in_xfer;
    logic [CMD_W-1:0]    in_cmd;
    t_slot               in_slot;
    logic [BYTE_W+9:0]   luma_sum;

    t_slot               shown;
    logic                lvl_start, k_start;
    logic [NUM_W-1:0]    k_num;
    logic [DEN_W-1:0]    k_den;
    logic                k_busy;
    logic [NUM_W-1:0]    k_quo;
    logic [NUM_W-1:0]    lvl_num [3];
    logic                lvl_busy [3];
    logic [NUM_W-1:0]    lvl_quo [3];
    logic                out_load;
    logic                all_idle;
    logic [STEPS-1:0]    mask;

    assign in_cmd  = i_s_axis_tuser;
    assign in_slot = i_s_axis_tdata[57:0];
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign luma_sum = 18'(LUMA_R) * 18'(in_slot.color[23:16])
                    + 18'(LUMA_G) * 18'(in_slot.color[15:8])
                    + 18'(LUMA_B) * 18'(in_slot.color[7:0]);

    // first lit slot wins, last slot when none is lit
    always_comb begin
        shown = r_slot[SLOT_COUNT-1];
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_slot[i].color != '0) begin
                shown = r_slot[i];
            end
        end
    end

    assign all_idle = !k_busy && !lvl_busy[0] && !lvl_busy[1] && !lvl_busy[2];

    always_comb begin
        n_state   = r_state;
        lvl_start = 1'b0;
        k_start   = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                lvl_start = 1'b1;
                k_start   = !r_kind;
                n_state   = S_DIV1;
            end
            S_DIV1: begin
                if (all_idle) begin
                    if (!r_kind && r_sync) begin
                        k_start = 1'b1;
                        n_state = S_DIV2;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV2: begin
                if (!k_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // k = on*15/(on+off) first, then step time on/(k+1) on the same unit
    always_comb begin
        if (r_state == S_START) begin
            k_num = {shown.on_ms, 4'b0} - NUM_W'(shown.on_ms);
            k_den = DEN_W'(shown.on_ms) + DEN_W'(shown.off_ms);
        end else begin
            k_num = NUM_W'(r_on);
            k_den = DEN_W'(k_quo[K_W-1:0]) + DEN_W'(1);
        end
    end

    always_comb begin
        if (r_kind) begin
            lvl_num[0] = NUM_W'(eff_max(r_bl_max)) * NUM_W'(r_luma);
        end else begin
            lvl_num[0] = NUM_W'(eff_max(r_red_max)) * NUM_W'(shown.color[23:16]);
        end
        lvl_num[1] = NUM_W'(eff_max(r_green_max)) * NUM_W'(shown.color[15:8]);
        lvl_num[2] = NUM_W'(eff_max(r_blue_max)) * NUM_W'(shown.color[7:0]);
    end

    srgb_div #(.N(NUM_W), .D(DEN_W)) u_k_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (k_start),
        .i_num   (k_num),
        .i_den   (k_den),
        .o_busy  (k_busy),
        .o_quo   (k_quo)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        srgb_div #(.N(NUM_W), .D(DEN_W)) u_lvl_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lvl_start),
            .i_num   (lvl_num[g]),
            .i_den   (BYTE_DIVISOR),
            .o_busy  (lvl_busy[g]),
            .o_quo   (lvl_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot[i] <= '0;
            end
        end else if (in_xfer && in_cmd != CMD_BACKLIGHT) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (int'(in_cmd) == i) begin
                    r_slot[i] <= in_slot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_max   <= FULL_SCALE;
            r_green_max <= FULL_SCALE;
            r_blue_max  <= FULL_SCALE;
            r_bl_max    <= FULL_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RED_MAX:       r_red_max   <= i_cfg_data;
                REG_GREEN_MAX:     r_green_max <= i_cfg_data;
                REG_BLUE_MAX:      r_blue_max  <= i_cfg_data;
                REG_BACKLIGHT_MAX: r_bl_max    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= (in_cmd == CMD_BACKLIGHT);
            r_luma <= luma_sum[BYTE_W+7:BYTE_W];
        end
        if (r_state == S_START) begin
            r_sync  <= (shown.mode != '0) && (shown.off_ms != '0);
            r_blink <= (shown.mode != '0);
            r_on    <= shown.on_ms;
            r_k     <= '0;
            r_dur   <= '0;
        end
        if (r_state == S_DIV1 && k_start) begin
            r_k <= k_quo[K_W-1:0];
        end
        if (r_state == S_DIV2 && !k_busy) begin
            r_dur <= k_quo[MS_W-1:0];
        end
    end

    assign mask = r_sync ? row_mask(r_k) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind <= r_kind;
            if (r_kind) begin
                r_out_data <= {5'b0, lvl_quo[0][LEVEL_W-1:0], 71'b0};
            end else begin
                r_out_data <= {5'b0, {LEVEL_W{1'b0}}, r_dur,
                               lvl_quo[2][LEVEL_W-1:0], lvl_quo[1][LEVEL_W-1:0],
                               lvl_quo[0][LEVEL_W-1:0], mask,
                               r_sync, r_blink, r_sync};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_units_idle_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !k_busy && !lvl_busy[0] && !lvl_busy[1] && !lvl_busy[2])
        else $error("divider busy while controller idle");

    a_backlight_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind |-> r_out_data[70:0] == '0)
        else $error("backlight result carries led fields");

    a_led_no_backlight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_kind |-> r_out_data[82:71] == '0)
        else $error("led result carries backlight level");

    a_pattern_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[2] == r_out_data[0])
                        && ((r_out_data[18:3] != '0) == r_out_data[2]))
        else $error("pattern flag and mask disagree");

    a_solid_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data[2] |-> r_out_data[70:55] == '0)
        else $error("step duration set without pattern");
`endif

endmodule

// File: rtl/srgb_div.sv
// ----------------------------------------------------------------------------
// srgb_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srgb_div #(
    parameter int N = 20,
    parameter int D = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_num,
    input  logic [D-1:0] i_den,
    output logic         o_busy,
    output logic [N-1:0] o_quo
);

    localparam int CW = $clog2(N + 1);

    logic [D-1:0]  r_rem;
    logic [N-1:0]  r_quo;
    logic [D-1:0]  r_den;
    logic [CW-1:0] r_cnt;

    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          fits;

    assign trial = {r_rem, r_quo[N-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(N);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[D-1:0] : trial[D-1:0];
            r_quo <= {r_quo[N-2:0], fits};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule
